FILE: src/sacx_pkg.sv
// Shared types and constants for the stack accumulator execute block.
package sacx_pkg;

  localparam int unsigned FUNC_W = 5;
  localparam int unsigned WORD_W = 16;

  typedef enum logic [4:0] {
    OP_NOP = 5'd0, OP_HLT = 5'd1,
    OP_MOVA = 5'd2, OP_MOVB = 5'd3, OP_MOVC = 5'd4, OP_MOVD = 5'd5, OP_MOVSP = 5'd6,
    OP_STE = 5'd7, OP_CLE = 5'd8, OP_STG = 5'd9, OP_CLG = 5'd10,
    OP_STH = 5'd11, OP_CLH = 5'd12, OP_STL = 5'd13, OP_CLL = 5'd14,
    OP_PUSH = 5'd15, OP_POP = 5'd16,
    OP_ADD = 5'd17, OP_SUB = 5'd18, OP_MUL = 5'd19, OP_DIV = 5'd20,
    OP_PRN = 5'd21, OP_JMP = 5'd22, OP_JZ = 5'd23, OP_JNZ = 5'd24
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_DIVZERO = 3'd1, ST_OVERFLOW = 3'd2,
    ST_UNDERFLOW = 3'd3, ST_BADREG = 3'd4, ST_ILLEGAL = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_MEM, S_DIV, S_DONE
  } state_t;

  // Divider handshake.
  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

FILE: src/stack_accumulator_cpu_execute.sv
// Top level: execute stage of a small stack/accumulator processor.
// One instruction enters on the in_ channel (tdata: func, operand) and one
// result leaves on the out_ channel with the full machine state after it.
// Stack words live in a 16-bit-wide memory of MEM_BYTES/2 words with one
// synchronous read port and one write port. The stack pointer is usually even
// and a word then sits in one row; an odd pointer splits it over two rows.
// A register op's result is loaded into the output register as it is accepted;
// PUSH and POP pass through the memory state, with extra phases for an odd stack
// pointer, and then the done state; DIV waits in the divide state for the
// shift-subtract divider.
// Throughput: a register op can be accepted every cycle while the receiver does
// not stall; PUSH, POP and DIV hold in_tready low until their result is loaded
// into the output register. After reset a clearing pass writes zero to every
// memory row, during which in_tready is low.
// The result is held in an output register; while the receiver stalls it
// stays valid and no new instruction is taken.
module stack_accumulator_cpu_execute #(
  parameter int unsigned MEM_BYTES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [23:0]  in_tdata,   // [4:0] func, [20:5] operand
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [111:0] out_tdata   // next_ip, acc_value, b_value, c_value,
                                   // d_value, stack_ptr, flag_bits,
                                   // print_strobe, halted, status
);
  import sacx_pkg::*;

  localparam int unsigned ROWS = MEM_BYTES / 2;
  localparam int unsigned RW   = $clog2(ROWS);

  logic [15:0] mem [ROWS];
  logic [15:0] rd_q;
  logic        we;
  logic [RW-1:0] waddr, raddr;
  logic [15:0] wdata;

  state_t state_r, state_nxt;
  logic [15:0] acc_r, b_r, c_r, d_r, sp_r, ip_r;
  logic [15:0] acc_nxt, b_nxt, c_nxt, d_nxt, sp_nxt, ip_nxt;
  logic [3:0]  fl_r, fl_nxt;
  logic [4:0]  op_r, op_nxt;
  logic [15:0] arg_r, arg_nxt;
  logic [15:0] val_r, val_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [RW:0] clr_r, clr_nxt;
  logic        ov_r, ov_nxt;
  logic [111:0] od_r, od_nxt;

  div_req_t dreq;
  div_rsp_t drsp;

  sacx_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  logic [4:0]  f;
  logic [15:0] a;
  logic [16:0] ip1, ip3;
  logic [16:0] spm2, spp;
  logic        odd;
  logic [15:0] rsel;
  logic [31:0] prod;
  status_t     st;
  logic        fin;
  logic        in_acc, out_free;

  assign f = in_tdata[4:0];
  assign a = in_tdata[20:5];
  assign out_free = !ov_r || out_tready;
  assign in_acc = in_tvalid && out_free && (state_r == S_IDLE);
  assign odd = sp_r[0];

  always_comb begin
    case (arg_r[1:0])
      2'd0: rsel = acc_r;
      2'd1: rsel = b_r;
      2'd2: rsel = c_r;
      default: rsel = d_r;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    acc_nxt = acc_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
    sp_nxt = sp_r; ip_nxt = ip_r; fl_nxt = fl_r;
    op_nxt = op_r; arg_nxt = arg_r; val_nxt = val_r; ph_nxt = ph_r;
    clr_nxt = clr_r; ov_nxt = ov_r; od_nxt = od_r;
    in_tready = 1'b0;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    dreq = '{start: 1'b0, dividend: acc_r, divisor: b_r};
    ip1 = {1'b0, ip_r} + 17'd1;
    ip3 = {1'b0, ip_r} + 17'd3;
    spm2 = {1'b0, sp_r} - 17'd2;
    spp = {1'b0, sp_r} + 17'd1;
    prod = acc_r * b_r;
    st = ST_OK;
    fin = 1'b0;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r[RW-1:0]; wdata = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (RW+1)'(ROWS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready = out_free;
        if (in_acc) begin
          op_nxt = f; arg_nxt = a;
          fin = 1'b1;
          case (f)
            OP_NOP: ip_nxt = ip1[15:0];
            OP_HLT: ip_nxt = ip1[15:0];
            OP_MOVA: begin acc_nxt = a; ip_nxt = ip3[15:0]; end
            OP_MOVB: begin b_nxt = a; ip_nxt = ip3[15:0]; end
            OP_MOVC: begin c_nxt = a; ip_nxt = ip3[15:0]; end
            OP_MOVD: begin d_nxt = a; ip_nxt = ip3[15:0]; end
            OP_MOVSP: begin sp_nxt = a; ip_nxt = ip3[15:0]; end
            OP_STE, OP_CLE, OP_STG, OP_CLG, OP_STH, OP_CLH, OP_STL, OP_CLL: begin
              logic [4:0] k;
              k = f - 5'd7;
              if (!k[0]) fl_nxt = fl_r | (4'd1 << k[2:1]);
              else       fl_nxt = fl_r & ~(4'd1 << k[2:1]);
              ip_nxt = ip1[15:0];
            end
            OP_PUSH: begin
              if (a > 16'd3) st = ST_BADREG;
              else if (sp_r < 16'd2 || {1'b0, sp_r} > 17'(MEM_BYTES)) st = ST_OVERFLOW;
              else begin
                fin = 1'b0; state_nxt = S_MEM; ph_nxt = 2'd0;
                // fetch row (sp-2)>>1; its data is used only when a half-word write is needed
                raddr = RW'(spm2[16:1]);
              end
            end
            OP_POP: begin
              if (a > 16'd3) st = ST_BADREG;
              else if ({1'b0, sp_r} > 17'(MEM_BYTES - 2)) st = ST_UNDERFLOW;
              else begin
                fin = 1'b0; state_nxt = S_MEM; ph_nxt = 2'd0;
                raddr = RW'(sp_r[15:1]);
              end
            end
            OP_ADD: begin acc_nxt = acc_r + b_r; ip_nxt = ip1[15:0]; end
            OP_SUB: begin acc_nxt = acc_r - b_r; ip_nxt = ip1[15:0]; end
            OP_MUL: begin acc_nxt = prod[15:0]; ip_nxt = ip1[15:0]; end
            OP_DIV: begin
              if (b_r == 16'd0) st = ST_DIVZERO;
              else begin
                fin = 1'b0; dreq.start = 1'b1; state_nxt = S_DIV;
              end
            end
            OP_PRN: ip_nxt = ip1[15:0];
            OP_JMP: ip_nxt = a;
            OP_JZ:  ip_nxt = (acc_r == 16'd0) ? a : ip3[15:0];
            OP_JNZ: ip_nxt = (acc_r != 16'd0) ? a : ip3[15:0];
            default: st = ST_ILLEGAL;
          endcase
          if (st != ST_OK) begin
            acc_nxt = acc_r; b_nxt = b_r; c_nxt = c_r; d_nxt = d_r;
            sp_nxt = sp_r; ip_nxt = ip_r; fl_nxt = fl_r;
          end
          if (fin) begin
            ov_nxt = 1'b1;
            od_nxt = {7'd0, st,
                      (st == ST_OK && f == OP_HLT),
                      (st == ST_OK && f == OP_PRN),
                      fl_nxt, sp_nxt, d_nxt, c_nxt, b_nxt, acc_nxt, ip_nxt};
          end
        end
      end
      S_DIV: begin
        if (drsp.done) begin
          acc_nxt = drsp.quotient; ip_nxt = ip1[15:0];
          state_nxt = S_DONE;
        end
      end
      S_MEM: begin
        // rd_q holds the row read in the previous cycle
        if (op_r == OP_PUSH) begin
          val_nxt = (ph_r == 2'd0) ? rsel : val_r;
          if (!odd) begin
            we = 1'b1; waddr = RW'(spm2[16:1]); wdata = rsel;
            sp_nxt = spm2[15:0]; ip_nxt = ip3[15:0]; state_nxt = S_DONE;
          end else if (ph_r == 2'd0) begin
            // low byte lands in the high half of row (sp-2)>>1
            we = 1'b1; waddr = RW'(spm2[16:1]); wdata = {rsel[7:0], rd_q[7:0]};
            raddr = RW'(sp_r[15:1]); ph_nxt = 2'd1;
          end else begin
            we = 1'b1; waddr = RW'(sp_r[15:1]); wdata = {rd_q[15:8], val_r[15:8]};
            sp_nxt = spm2[15:0]; ip_nxt = ip3[15:0]; state_nxt = S_DONE;
          end
        end else begin
          if (!odd) begin
            val_nxt = rd_q; state_nxt = S_DONE;
          end else if (ph_r == 2'd0) begin
            val_nxt = {8'd0, rd_q[15:8]};
            raddr = RW'(spp[16:1]); ph_nxt = 2'd1;
          end else if (ph_r == 2'd1) begin
            ph_nxt = 2'd2;
            raddr = RW'(spp[16:1]);
          end else begin
            val_nxt = {rd_q[7:0], val_r[7:0]}; state_nxt = S_DONE;
          end
          if (state_nxt == S_DONE) begin
            case (arg_r[1:0])
              2'd0: acc_nxt = val_nxt;
              2'd1: b_nxt = val_nxt;
              2'd2: c_nxt = val_nxt;
              default: d_nxt = val_nxt;
            endcase
            sp_nxt = sp_r + 16'd2; ip_nxt = ip3[15:0];
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {7'd0, ST_OK, 1'b0, 1'b0, fl_r, sp_r, d_r, c_r, b_r, acc_r, ip_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; ov_r <= 1'b0;
      acc_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0;
      sp_r <= '0; ip_r <= '0; fl_r <= '0; ph_r <= '0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
      acc_r <= acc_nxt; b_r <= b_nxt; c_r <= c_nxt; d_r <= d_nxt;
      sp_r <= sp_nxt; ip_r <= ip_nxt; fl_r <= fl_nxt; ph_r <= ph_nxt;
    end
    op_r <= op_nxt; arg_r <= arg_nxt; val_r <= val_nxt; od_r <= od_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;

`ifndef NO_ASSERTIONS
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result dropped under stall");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    drsp.done |-> (state_r == S_DIV)) else $error("stray divider result");
`endif
endmodule

FILE: src/sacx_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sacx_div (
  input  logic             clk,
  input  logic             rst_n,
  input  sacx_pkg::div_req_t req,
  output sacx_pkg::div_rsp_t rsp
);
  import sacx_pkg::*;

  logic [15:0] q_r, q_nxt, d_r, d_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0] trial;

  always_comb begin
    q_nxt = q_r; d_nxt = d_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r[15:0], q_r[15]} - {1'b0, d_r};
    if (req.start) begin
      q_nxt = req.dividend; d_nxt = req.divisor; rem_nxt = '0;
      cnt_nxt = 5'd16; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[16]) begin
        rem_nxt = trial;
        q_nxt = {q_r[14:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[15]};
        q_nxt = {q_r[14:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; d_r <= d_nxt; rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = q_r;
endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the stack accumulator execute stage.
`timescale 1ns / 100ps

module testbench;
  import sacx_pkg::*;

  localparam int unsigned MEM_SIZE   = 65536;
  localparam int unsigned WDOG_LIMIT = 200000;
  localparam int unsigned N_RANDOM   = 930;

  typedef struct packed {
    status_t     status;
    logic        halted;
    logic        print_strobe;
    logic [3:0]  flag_bits;
    logic [15:0] stack_ptr;
    logic [15:0] d_value;
    logic [15:0] c_value;
    logic [15:0] b_value;
    logic [15:0] acc_value;
    logic [15:0] next_ip;
  } cpu_state_t;

  typedef struct {
    logic [4:0]  func;
    logic [15:0] operand;
    bit          typed;
    status_t     status;
  } instr_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [23:0]  in_tdata = '0;   // [4:0] func, [20:5] operand
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [111:0] out_tdata;       // next_ip, acc, b, c, d, sp, flags, print, halted, status

  // Model copy of the machine state
  logic [15:0] m_acc, m_b, m_c, m_d, m_sp, m_ip;
  logic [3:0]  m_flags;
  logic [7:0]  m_stack [MEM_SIZE];

  cpu_state_t  expected_states [$];
  instr_row_t  directed_rows [$];
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;

  stack_accumulator_cpu_execute #(.MEM_BYTES(MEM_SIZE)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [15:0] read_reg(input logic [1:0] n);
    case (n)
      2'd0: return m_acc;
      2'd1: return m_b;
      2'd2: return m_c;
      default: return m_d;
    endcase
  endfunction

  task automatic write_reg(input logic [1:0] n, input logic [15:0] v);
    case (n)
      2'd0: m_acc = v;
      2'd1: m_b = v;
      2'd2: m_c = v;
      default: m_d = v;
    endcase
  endtask

  task automatic execute_instr(input logic [4:0] func, input logic [15:0] operand,
                               output cpu_state_t res);
    logic [15:0] nip;
    logic [15:0] addr;
    status_t     st;
    logic        prn, hlt;
    st = ST_OK;
    prn = 1'b0;
    hlt = 1'b0;
    if (func inside {[OP_MOVA:OP_MOVSP], OP_PUSH, OP_POP, [OP_JMP:OP_JNZ]})
      nip = m_ip + 16'd3;
    else
      nip = m_ip + 16'd1;
    case (func)
      OP_NOP: ;
      OP_HLT: hlt = 1'b1;
      OP_MOVA, OP_MOVB, OP_MOVC, OP_MOVD: write_reg(2'(func - OP_MOVA), operand);
      OP_MOVSP: m_sp = operand;
      OP_STE, OP_CLE, OP_STG, OP_CLG, OP_STH, OP_CLH, OP_STL, OP_CLL: begin
        if (((func - OP_STE) & 1) == 0)
          m_flags[(func - OP_STE) >> 1] = 1'b1;
        else
          m_flags[(func - OP_STE) >> 1] = 1'b0;
      end
      OP_PUSH: begin
        if (operand > 3) st = ST_BADREG;
        else if (m_sp < 2 || m_sp > MEM_SIZE) st = ST_OVERFLOW;
        else begin
          addr = m_sp - 16'd2;
          {m_stack[addr + 16'd1], m_stack[addr]} = read_reg(operand[1:0]);
          m_sp = addr;
        end
      end
      OP_POP: begin
        if (operand > 3) st = ST_BADREG;
        else if (m_sp > MEM_SIZE - 2) st = ST_UNDERFLOW;
        else begin
          addr = m_sp;
          m_sp = m_sp + 16'd2;
          write_reg(operand[1:0], {m_stack[addr + 16'd1], m_stack[addr]});
        end
      end
      OP_ADD: m_acc = m_acc + m_b;
      OP_SUB: m_acc = m_acc - m_b;
      OP_MUL: m_acc = m_acc * m_b;
      OP_DIV: begin
        if (m_b == 0) st = ST_DIVZERO;
        else m_acc = m_acc / m_b;
      end
      OP_PRN: prn = 1'b1;
      OP_JMP: nip = operand;
      OP_JZ:  if (m_acc == 0) nip = operand;
      OP_JNZ: if (m_acc != 0) nip = operand;
      default: st = ST_ILLEGAL;
    endcase
    if (st == ST_OK) m_ip = nip;
    else begin
      prn = 1'b0;
      hlt = 1'b0;
    end
    res = '{status: st, halted: hlt, print_strobe: prn, flag_bits: m_flags,
            stack_ptr: m_sp, d_value: m_d, c_value: m_c, b_value: m_b,
            acc_value: m_acc, next_ip: m_ip};
  endtask

  task automatic add_row(input logic [4:0] f, input logic [15:0] o,
                         input bit t, input status_t s);
    instr_row_t r;
    r.func = f;
    r.operand = o;
    r.typed = t;
    r.status = s;
    directed_rows.push_back(r);
  endtask

  // Hold valid across back-to-back items; lower it only for a gap.
  task automatic send_instr(input logic [4:0] func, input logic [15:0] operand,
                            input bit typed, input status_t st);
    cpu_state_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {3'b000, operand, func};
    do @(posedge clk); while (!in_tready);
    execute_instr(func, operand, res);
    if (typed) res.status = st;
    expected_states.push_back(res);
  endtask

  task automatic random_instr(output logic [4:0] f, output logic [15:0] o);
    int unsigned pick;
    pick = $urandom_range(99);
    o = 16'($urandom);
    if (pick < 25) f = 5'(OP_MOVA + $urandom_range(3));
    else if (pick < 30) begin
      f = OP_MOVSP;
      case ($urandom_range(3))
        0: o = 16'($urandom_range(0, 40));
        1: o = 16'(16'hFFFF - $urandom_range(0, 40));
        2: o = 16'({$urandom_range(1, 32), 1'b0});
        default: o = 16'($urandom);
      endcase
    end else if (pick < 45) begin
      f = OP_PUSH;
      if ($urandom_range(9) != 0) o = 16'($urandom_range(3));
    end else if (pick < 60) begin
      f = OP_POP;
      if ($urandom_range(9) != 0) o = 16'($urandom_range(3));
    end else if (pick < 78) f = 5'(OP_ADD + $urandom_range(3));
    else if (pick < 86) f = 5'(OP_STE + $urandom_range(7));
    else if (pick < 94) f = 5'(OP_PRN + $urandom_range(3));
    else if (pick < 97) f = 5'($urandom_range(1));
    else f = 5'($urandom_range(25, 31));
  endtask

  // Receiver side: random stall, result check and idle watchdog.
  always @(posedge clk) begin
    cpu_state_t got, want;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("stack_accumulator_cpu_execute verification failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[$bits(cpu_state_t)-1:0];
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transfer %h", got);
      end else begin
        want = expected_states.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp ip=%h a=%h b=%h c=%h d=%h sp=%h f=%h p=%b h=%b st=%0d\n",
                      "          got ip=%h a=%h b=%h c=%h d=%h sp=%h f=%h p=%b h=%b st=%0d"},
                     want.next_ip, want.acc_value, want.b_value, want.c_value,
                     want.d_value, want.stack_ptr, want.flag_bits, want.print_strobe,
                     want.halted, want.status,
                     got.next_ip, got.acc_value, got.b_value, got.c_value,
                     got.d_value, got.stack_ptr, got.flag_bits, got.print_strobe,
                     got.halted, got.status);
        end
      end
    end
  end

  initial begin
    logic [4:0]  f;
    logic [15:0] o;
    m_acc = 0; m_b = 0; m_c = 0; m_d = 0; m_sp = 0; m_ip = 0; m_flags = 0;
    for (int i = 0; i < MEM_SIZE; i++) m_stack[i] = 8'h00;

    add_row(OP_NOP, 16'h0000, 1, ST_OK);
    add_row(OP_PRN, 16'h0000, 1, ST_OK);
    add_row(OP_HLT, 16'hFFFF, 1, ST_OK);
    add_row(OP_PUSH, 16'h0000, 1, ST_OVERFLOW);   // stack pointer zero
    add_row(OP_POP, 16'h0001, 1, ST_OK);          // reads cleared memory
    add_row(OP_PUSH, 16'h0004, 1, ST_BADREG);
    add_row(OP_POP, 16'hFFFF, 1, ST_BADREG);
    add_row(OP_MOVA, 16'hFFFF, 1, ST_OK);
    add_row(OP_DIV, 16'h0000, 1, ST_DIVZERO);
    add_row(OP_MOVB, 16'hFFFF, 1, ST_OK);
    add_row(OP_ADD, 16'h0000, 0, ST_OK);
    add_row(OP_MUL, 16'h0000, 0, ST_OK);
    add_row(OP_SUB, 16'h0000, 0, ST_OK);
    add_row(OP_DIV, 16'h0000, 0, ST_OK);
    for (int k = OP_STE; k <= OP_CLL; k++) add_row(5'(k), 16'h0000, 1, ST_OK);
    add_row(OP_STL, 16'h0000, 1, ST_OK);
    add_row(OP_MOVSP, 16'hFFFF, 1, ST_OK);
    add_row(OP_POP, 16'h0000, 1, ST_UNDERFLOW);
    add_row(OP_MOVSP, 16'hFFFE, 1, ST_OK);
    add_row(OP_MOVC, 16'hA5A5, 1, ST_OK);
    add_row(OP_PUSH, 16'h0002, 1, ST_OK);
    add_row(OP_MOVD, 16'h0000, 1, ST_OK);
    add_row(OP_POP, 16'h0003, 0, ST_OK);
    add_row(OP_JZ, 16'h1234, 0, ST_OK);
    add_row(OP_JNZ, 16'hFFFF, 0, ST_OK);
    add_row(OP_JMP, 16'hFFFE, 0, ST_OK);
    add_row(5'd31, 16'hFFFF, 1, ST_ILLEGAL);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_instr(directed_rows[i].func, directed_rows[i].operand,
                 directed_rows[i].typed, directed_rows[i].status);

    for (int n = 0; n < N_RANDOM; n++) begin
      case (n * 5 / N_RANDOM)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        3: begin idle_pct = 21; stall_pct = 21; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      random_instr(f, o);
      send_instr(f, o, 0, ST_OK);
    end
    in_tvalid <= 1'b0;

    while (expected_states.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("stack_accumulator_cpu_execute verification clean");
    else
      $display("stack_accumulator_cpu_execute verification failed");
    $finish;
  end

endmodule

FILE: stack_accumulator_cpu_execute.f
src/sacx_pkg.sv
src/sacx_div.sv
src/stack_accumulator_cpu_execute.sv
tb/sv/testbench.sv
